FILE: rtl/datetime_text_to_epoch_millis_defines.svh
// Assertion helpers for the timestamp converter.
`ifndef DATETIME_TEXT_TO_EPOCH_MILLIS_DEFINES_SVH
`define DATETIME_TEXT_TO_EPOCH_MILLIS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTE_ASSERT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("dte check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DTE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("dte check failed");

`endif

FILE: rtl/dte_pkg.sv
`timescale 1ns / 1ps
package dte_pkg;

  localparam int unsigned DefQueueDepth = 2;

  // string lengths
  localparam int unsigned MaxLen   = 23;
  localparam int unsigned ShortLen = 19;

  // end of each digit field (exclusive position)
  localparam int unsigned YearEnd   = 4;
  localparam int unsigned MonthEnd  = 7;
  localparam int unsigned DayEnd    = 10;
  localparam int unsigned HourEnd   = 13;
  localparam int unsigned MinuteEnd = 16;
  localparam int unsigned SecondEnd = 19;

  // separator positions
  localparam int unsigned PosDash1  = 4;
  localparam int unsigned PosDash2  = 7;
  localparam int unsigned PosSpace  = 10;
  localparam int unsigned PosColon1 = 13;
  localparam int unsigned PosColon2 = 16;
  localparam int unsigned PosDot    = 19;

  localparam logic [7:0] SepNone   = 8'h00;
  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  // range limits
  localparam int unsigned MaxHour   = 23;
  localparam int unsigned MaxMinute = 59;
  localparam int unsigned MaxSecond = 59;
  localparam int unsigned MaxMilli  = 999;

  // calendar arithmetic
  localparam int unsigned EraYears    = 400;
  localparam int unsigned DaysPerEra  = 146097;
  localparam int unsigned DaysPerYear = 365;
  // epoch offset 719468 plus one era, since years are biased by 400
  localparam int unsigned DayBias     = 865565;
  localparam int unsigned HoursPerDay = 24;
  localparam int unsigned MinPerHour  = 60;
  localparam int unsigned SecPerMin   = 60;
  localparam int unsigned MsPerSec    = 1000;

  // reciprocals: floor(x / 400) = (x * 10486) >> 22 for x < 16384, etc.
  localparam int unsigned RecipEra   = 10486;
  localparam int unsigned EraShift   = 22;
  localparam int unsigned RecipCent  = 41;
  localparam int unsigned CentShift  = 12;
  localparam int unsigned Recip100   = 5243;
  localparam int unsigned Shift100   = 19;
  localparam int unsigned Hundred    = 100;

  localparam longint MinEpochMs = -64'sd62167219200000;
  localparam longint MaxEpochMs = 64'sd253402300799999;

  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [9:0]  milli;
    logic        long_form;
    logic        fmt_ok;
  } dte_rec_t;

  typedef enum logic [3:0] {
    BkIdle,
    BkCheck,
    BkEra,
    BkYoe,
    BkDoe,
    BkDays,
    BkHour,
    BkMin,
    BkSec,
    BkMilli,
    BkOut
  } bk_state_e;

  function automatic logic [7:0] sep_char(input logic [4:0] pos);
    logic [7:0] c;
    case (pos)
      5'(PosDash1), 5'(PosDash2):   c = CharDash;
      5'(PosSpace):                 c = CharSpace;
      5'(PosColon1), 5'(PosColon2): c = CharColon;
      5'(PosDot):                   c = CharDot;
      default:                      c = SepNone;
    endcase
    return c;
  endfunction

  function automatic logic is_leap(input logic [13:0] y);
    logic [26:0] prod;
    logic [7:0]  q100;
    logic [13:0] r100;
    prod = 27'(y) * 27'(Recip100);
    q100 = prod[Shift100 +: 8];
    r100 = y - 14'(q100) * 14'(Hundred);
    // divisible by 400 <=> divisible by 100 with quotient divisible by 4
    return (y[1:0] == 2'b00) && ((r100 != '0) || (q100[1:0] == 2'b00));
  endfunction

  function automatic logic [4:0] month_days(input logic [13:0] y, input logic [6:0] m);
    logic [4:0] d;
    case (m)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: d = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    d = 5'd30;
      7'd2:                                       d = is_leap(y) ? 5'd29 : 5'd28;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

  // days from March 1 to the first of the month
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] o;
    case (m)
      4'd3:    o = 9'd0;
      4'd4:    o = 9'd31;
      4'd5:    o = 9'd61;
      4'd6:    o = 9'd92;
      4'd7:    o = 9'd122;
      4'd8:    o = 9'd153;
      4'd9:    o = 9'd184;
      4'd10:   o = 9'd214;
      4'd11:   o = 9'd245;
      4'd12:   o = 9'd275;
      4'd1:    o = 9'd306;
      4'd2:    o = 9'd337;
      default: o = 9'd0;
    endcase
    return o;
  endfunction

endpackage

FILE: rtl/dte_in_if.sv
`timescale 1ns / 1ps
interface dte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink (input valid, input character, input last_char, output ready);
endinterface

FILE: rtl/dte_out_if.sv
`timescale 1ns / 1ps
interface dte_out_if;
  logic               valid;
  logic               ready;
  logic signed [48:0] epoch_millis;
  logic               valid_res;

  modport source (output valid, output epoch_millis, output valid_res, input ready);
  modport sink (input valid, input epoch_millis, input valid_res, output ready);
endinterface

FILE: rtl/dte_front.sv
`timescale 1ns / 1ps
module dte_front
  import dte_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  dte_in_if.sink   chr_i,
  input  logic     q_full_i,
  output logic     push_o,
  output dte_rec_t rec_o
);

  logic [4:0]  pos_q, pos_d;
  logic [13:0] year_q, year_d, year_upd;
  logic [6:0]  month_q, month_d, month_upd;
  logic [6:0]  day_q, day_d, day_upd;
  logic [6:0]  hour_q, hour_d, hour_upd;
  logic [6:0]  minute_q, minute_d, minute_upd;
  logic [6:0]  second_q, second_d, second_upd;
  logic [9:0]  milli_q, milli_d, milli_upd;
  logic        err_q, err_d;

  logic       accept;
  logic       in_range;
  logic [7:0] exp_sep;
  logic       is_digit;
  logic [3:0] digit;
  logic       char_err;
  logic       dig_ok;
  logic       err_now;
  logic [4:0] len;

  assign chr_i.ready = ~q_full_i;
  assign accept      = chr_i.valid & chr_i.ready;

  assign in_range = pos_q < 5'(MaxLen);
  assign exp_sep  = sep_char(pos_q);
  assign is_digit = (chr_i.character >= CharZero) && (chr_i.character <= CharNine);
  assign digit    = chr_i.character[3:0];
  assign char_err = ~in_range ||
                    ((exp_sep != SepNone) ? (chr_i.character != exp_sep) : ~is_digit);
  assign dig_ok   = in_range && (exp_sep == SepNone) && is_digit;
  assign err_now  = err_q | char_err;
  assign len      = pos_q + 5'd1;

  always_comb begin
    year_upd   = year_q;
    month_upd  = month_q;
    day_upd    = day_q;
    hour_upd   = hour_q;
    minute_upd = minute_q;
    second_upd = second_q;
    milli_upd  = milli_q;
    if (dig_ok) begin
      if (pos_q < 5'(YearEnd)) begin
        year_upd = year_q * 14'd10 + 14'(digit);
      end else if (pos_q < 5'(MonthEnd)) begin
        month_upd = month_q * 7'd10 + 7'(digit);
      end else if (pos_q < 5'(DayEnd)) begin
        day_upd = day_q * 7'd10 + 7'(digit);
      end else if (pos_q < 5'(HourEnd)) begin
        hour_upd = hour_q * 7'd10 + 7'(digit);
      end else if (pos_q < 5'(MinuteEnd)) begin
        minute_upd = minute_q * 7'd10 + 7'(digit);
      end else if (pos_q < 5'(SecondEnd)) begin
        second_upd = second_q * 7'd10 + 7'(digit);
      end else begin
        milli_upd = milli_q * 10'd10 + 10'(digit);
      end
    end
  end

  always_comb begin
    pos_d    = pos_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    milli_d  = milli_q;
    err_d    = err_q;
    if (accept) begin
      if (chr_i.last_char) begin
        pos_d    = '0;
        year_d   = '0;
        month_d  = '0;
        day_d    = '0;
        hour_d   = '0;
        minute_d = '0;
        second_d = '0;
        milli_d  = '0;
        err_d    = 1'b0;
      end else begin
        pos_d    = in_range ? pos_q + 5'd1 : pos_q;
        year_d   = year_upd;
        month_d  = month_upd;
        day_d    = day_upd;
        hour_d   = hour_upd;
        minute_d = minute_upd;
        second_d = second_upd;
        milli_d  = milli_upd;
        err_d    = err_now;
      end
    end
  end

  // record of the finished string, taken on the last character
  assign push_o          = accept & chr_i.last_char;
  assign rec_o.year      = year_upd;
  assign rec_o.month     = month_upd;
  assign rec_o.day       = day_upd;
  assign rec_o.hour      = hour_upd;
  assign rec_o.minute    = minute_upd;
  assign rec_o.second    = second_upd;
  assign rec_o.milli     = milli_upd;
  assign rec_o.long_form = (len == 5'(MaxLen));
  assign rec_o.fmt_ok    = ~err_now && ((len == 5'(ShortLen)) || (len == 5'(MaxLen)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
      milli_q  <= '0;
      err_q    <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      milli_q  <= milli_d;
      err_q    <= err_d;
    end
  end

endmodule

FILE: rtl/dte_queue.sv
`timescale 1ns / 1ps
module dte_queue
  import dte_pkg::*;
#(
  parameter int unsigned Depth = DefQueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  dte_rec_t rec_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output dte_rec_t rec_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dte_rec_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

FILE: rtl/dte_back.sv
`timescale 1ns / 1ps
module dte_back
  import dte_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      rec_valid_i,
  input  dte_rec_t  rec_i,
  output logic      pop_o,
  dte_out_if.source res_o
);

  bk_state_e   st_q, st_d;
  dte_rec_t    rec_q, rec_d;
  logic        ok_q, ok_d;
  logic [13:0] yp_q, yp_d;
  logic [8:0]  doy_q, doy_d;
  logic [4:0]  era_q, era_d;
  logic [8:0]  yoe_q, yoe_d;
  logic [17:0] doe_q, doe_d;
  logic [48:0] acc_q, acc_d;
  logic        out_valid_q, out_valid_d;
  logic [48:0] out_ms_q, out_ms_d;
  logic        out_vr_q, out_vr_d;

  logic        out_free;
  logic        out_load;
  logic [26:0] era_prod;
  logic [13:0] cent_prod;
  logic [1:0]  yoe_cent;
  logic [4:0]  mdays;

  assign out_free  = ~out_valid_q | res_o.ready;
  assign era_prod  = 27'(yp_q) * 27'(RecipEra);
  assign cent_prod = 14'(yoe_q) * 14'(RecipCent);
  assign yoe_cent  = cent_prod[CentShift +: 2];
  assign mdays     = month_days(rec_q.year, rec_q.month);

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      BkIdle:  if (rec_valid_i) st_d = BkCheck;
      BkCheck: st_d = BkEra;
      BkEra:   st_d = BkYoe;
      BkYoe:   st_d = BkDoe;
      BkDoe:   st_d = BkDays;
      BkDays:  st_d = BkHour;
      BkHour:  st_d = BkMin;
      BkMin:   st_d = BkSec;
      BkSec:   st_d = BkMilli;
      BkMilli: st_d = BkOut;
      BkOut:   if (out_free) st_d = BkIdle;
      default: st_d = BkIdle;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o    = 1'b0;
    out_load = 1'b0;
    case (st_q)
      BkIdle:  pop_o = rec_valid_i;
      BkOut:   out_load = out_free;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    rec_d = rec_q;
    ok_d  = ok_q;
    yp_d  = yp_q;
    doy_d = doy_q;
    era_d = era_q;
    yoe_d = yoe_q;
    doe_d = doe_q;
    acc_d = acc_q;
    if (pop_o) begin
      rec_d = rec_i;
    end
    case (st_q)
      BkCheck: begin
        ok_d  = rec_q.fmt_ok && (rec_q.day != '0) && (rec_q.day <= 7'(mdays)) &&
                (rec_q.hour <= 7'(MaxHour)) && (rec_q.minute <= 7'(MaxMinute)) &&
                (rec_q.second <= 7'(MaxSecond)) && (rec_q.milli <= 10'(MaxMilli));
        // year shifted to start in March, biased by one era to stay positive
        yp_d  = rec_q.year + 14'(EraYears) - 14'(rec_q.month <= 7'd2);
        doy_d = month_offset(rec_q.month[3:0]) + 9'(rec_q.day) - 9'd1;
      end
      BkEra:   era_d = era_prod[EraShift +: 5];
      BkYoe:   yoe_d = 9'(yp_q - 14'(era_q) * 14'(EraYears));
      BkDoe: begin
        doe_d = 18'(yoe_q) * 18'(DaysPerYear) + 18'(yoe_q[8:2]) - 18'(yoe_cent) +
                18'(doy_q);
      end
      BkDays:  acc_d = 49'(era_q) * 49'(DaysPerEra) + 49'(doe_q) - 49'(DayBias);
      BkHour:  acc_d = acc_q * 49'(HoursPerDay) + 49'(rec_q.hour);
      BkMin:   acc_d = acc_q * 49'(MinPerHour) + 49'(rec_q.minute);
      BkSec:   acc_d = acc_q * 49'(SecPerMin) + 49'(rec_q.second);
      BkMilli: acc_d = acc_q * 49'(MsPerSec) + (rec_q.long_form ? 49'(rec_q.milli) : '0);
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q & ~res_o.ready;
    out_ms_d    = out_ms_q;
    out_vr_d    = out_vr_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_ms_d    = ok_q ? acc_q : '0;
      out_vr_d    = ok_q;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.epoch_millis = out_ms_q;
  assign res_o.valid_res    = out_vr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q    <= rec_d;
    ok_q     <= ok_d;
    yp_q     <= yp_d;
    doy_q    <= doy_d;
    era_q    <= era_d;
    yoe_q    <= yoe_d;
    doe_q    <= doe_d;
    acc_q    <= acc_d;
    out_ms_q <= out_ms_d;
    out_vr_q <= out_vr_d;
  end

endmodule

FILE: rtl/datetime_text_to_epoch_millis.sv
// Text timestamp to Unix milliseconds.
// chr_i (sink): one ASCII character per beat, last_char set on the final
//   character of "YYYY-MM-DD hh:mm:ss" or "YYYY-MM-DD hh:mm:ss.mmm".
// res_o (source): one beat per string: signed epoch_millis and valid_res;
//   a string that fails a length, separator, digit or range check gives
//   epoch_millis = 0 with valid_res = 0.
// Throughput: one character per cycle while the queue is not full.
//   Conversion runs in the back end one string at a time, through its
//   check, date, hour, minute, second and millisecond steps into the
//   output register, so strings of 19 characters and more do not stall
//   the input while the receiver takes each result.
// A record queue (QueueDepth entries) sits between the character parser
//   and the converter; the parser holds off every character while the
//   queue is full.
// Reset clears the parser state, the queue and the output register.
// When the receiver stalls, the result is held in the output register,
//   the converter waits behind it and the queue, then the input, fill up.
`timescale 1ns / 1ps
module datetime_text_to_epoch_millis
  import dte_pkg::*;
#(
  parameter int unsigned QueueDepth = DefQueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dte_in_if.sink    chr_i,
  dte_out_if.source res_o
);

  logic     q_push;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;
  dte_rec_t q_rec_in;
  dte_rec_t q_rec_out;

  // front end: per-character checks and field accumulation
  dte_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .chr_i    (chr_i),
    .q_full_i (q_full),
    .push_o   (q_push),
    .rec_o    (q_rec_in)
  );

  // decouples the parser from the multi-cycle conversion
  dte_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .rec_i   (q_rec_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rec_o   (q_rec_out)
  );

  // back end: range checks, civil-days conversion, scaling to ms
  dte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (q_valid),
    .rec_i       (q_rec_out),
    .pop_o       (q_pop),
    .res_o       (res_o)
  );

endmodule

FILE: rtl/dte_checker.sv
`timescale 1ns / 1ps
`include "datetime_text_to_epoch_millis_defines.svh"
module dte_checker
  import dte_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               chr_valid_i,
  input logic               chr_ready_i,
  input logic               chr_last_i,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input logic signed [48:0] res_ms_i,
  input logic               res_vr_i
);

  logic [7:0] pend_q, pend_d;
  logic       str_end;
  logic       res_take;

  assign str_end  = chr_valid_i & chr_ready_i & chr_last_i;
  assign res_take = res_valid_i & res_ready_i;
  assign pend_d   = pend_q + 8'(str_end) - 8'(res_take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // every result belongs to a string that has ended
  `DTE_ASSERT(a_res_has_string, clk_i, rst_ni, res_valid_i, pend_q != '0)
  // a failed string reports zero
  `DTE_ASSERT(a_bad_is_zero, clk_i, rst_ni, res_valid_i && !res_vr_i, res_ms_i == '0)
  // a good string lands inside years 0000..9999
  `DTE_ASSERT(a_good_in_range, clk_i, rst_ni, res_valid_i && res_vr_i, (res_ms_i >= MinEpochMs) && (res_ms_i <= MaxEpochMs))
  // stalled result holds
  `DTE_ASSERT_NXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(res_ms_i) && $stable(res_vr_i))

endmodule

bind datetime_text_to_epoch_millis dte_checker u_dte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .chr_valid_i (chr_i.valid),
  .chr_ready_i (chr_i.ready),
  .chr_last_i  (chr_i.last_char),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_ms_i    (res_o.epoch_millis),
  .res_vr_i    (res_o.valid_res)
);

FILE: verif/datetime_text_to_epoch_millis_tb.sv
`timescale 1ns / 1ps
// Testbench for the text timestamp converter.
// Characters stream in on chr_if; each string closes with last_char set and
// yields one result beat on res_if. A behavioral predictor tracks the parser
// state per accepted character and queues the expected epoch value. The
// monitor pops and compares field by field.
module datetime_text_to_epoch_millis_tb;
  import dte_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  typedef struct packed {
    logic signed [48:0] millis;
    logic               ok;
  } stamp_res_t;

  logic clk_i;
  logic rst_ni;

  dte_in_if  chr_if ();
  dte_out_if res_if ();

  datetime_text_to_epoch_millis uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .chr_i (chr_if.sink),
    .res_o (res_if.source)
  );

  // ---------------------------------------------------------------------
  // Clock, reset, known values on every input from time zero
  // ---------------------------------------------------------------------
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    rst_ni           = 1'b0;
    chr_if.valid     = 1'b0;
    chr_if.character = 8'h00;
    chr_if.last_char = 1'b0;
    res_if.ready     = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------
  char_beat_t  text_beats[$];      // characters not yet accepted, in order
  stamp_res_t  expected_stamps[$]; // one entry per string still in flight
  int unsigned chars_offered = 0;
  int unsigned chars_taken   = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;

  // Predictor state, mirrors the parser
  logic [4:0]  txt_pos;
  logic [13:0] yr_acc;
  logic [6:0]  mon_acc, day_acc, hr_acc, min_acc, sec_acc;
  logic [9:0]  ms_acc;
  logic        bad_text;

  function automatic logic [7:0] separator_at(input logic [4:0] pos);
    case (pos)
      5'(PosDash1), 5'(PosDash2):   return CharDash;
      5'(PosSpace):                 return CharSpace;
      5'(PosColon1), 5'(PosColon2): return CharColon;
      5'(PosDot):                   return CharDot;
      default:                      return SepNone;
    endcase
  endfunction

  function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
    bit leap;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Day count from 1970-01-01; March-based year so the leap day lands last.
  function automatic longint days_since_epoch(input int unsigned y_in,
                                              input int unsigned m,
                                              input int unsigned d);
    longint y, era, yoe, mp, doy, doe;
    y   = longint'(y_in) - ((m <= 2) ? 1 : 0);
    era = ((y >= 0) ? y : y - 399) / 400;
    yoe = y - era * 400;
    mp  = (m > 2) ? longint'(m) - 3 : longint'(m) + 9;
    doy = (153 * mp + 2) / 5 + longint'(d) - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  task automatic clear_parse();
    txt_pos  = '0;
    yr_acc   = '0;
    mon_acc  = '0;
    day_acc  = '0;
    hr_acc   = '0;
    min_acc  = '0;
    sec_acc  = '0;
    ms_acc   = '0;
    bad_text = 1'b0;
  endtask

  // Feed one accepted character; on the closing one, queue the expectation.
  task automatic absorb_char(input logic [7:0] ch, input logic last);
    logic [7:0]  want;
    int unsigned dig;
    int unsigned len;
    bit          ok;
    longint      ms;
    stamp_res_t  res;
    if (txt_pos >= 5'(MaxLen)) begin
      bad_text = 1'b1;
    end else begin
      want = separator_at(txt_pos);
      if (want != SepNone) begin
        if (ch != want) bad_text = 1'b1;
      end else if (ch < CharZero || ch > CharNine) begin
        bad_text = 1'b1;
      end else begin
        dig = ch - CharZero;
        if (txt_pos < 5'(YearEnd))        yr_acc  = 14'(yr_acc * 10 + dig);
        else if (txt_pos < 5'(MonthEnd))  mon_acc = 7'(mon_acc * 10 + dig);
        else if (txt_pos < 5'(DayEnd))    day_acc = 7'(day_acc * 10 + dig);
        else if (txt_pos < 5'(HourEnd))   hr_acc  = 7'(hr_acc * 10 + dig);
        else if (txt_pos < 5'(MinuteEnd)) min_acc = 7'(min_acc * 10 + dig);
        else if (txt_pos < 5'(SecondEnd)) sec_acc = 7'(sec_acc * 10 + dig);
        else                              ms_acc  = 10'(ms_acc * 10 + dig);
      end
    end

    if (!last) begin
      if (txt_pos < 5'(MaxLen)) txt_pos = txt_pos + 5'd1;
      return;
    end

    len = txt_pos + 1;
    ok  = !bad_text && (len == ShortLen || len == MaxLen);
    if (ok && (day_acc < 1 || day_acc > days_in_month(yr_acc, mon_acc) ||
               hr_acc > MaxHour || min_acc > MaxMinute || sec_acc > MaxSecond ||
               ms_acc > MaxMilli))
      ok = 1'b0;
    ms = 0;
    if (ok)
      ms = (((days_since_epoch(yr_acc, mon_acc, day_acc) * 24 + longint'(hr_acc)) * 60 +
             longint'(min_acc)) * 60 + longint'(sec_acc)) * 1000 +
           ((len == MaxLen) ? longint'(ms_acc) : 0);
    res.millis = ok ? ms[48:0] : '0;
    res.ok     = ok;
    expected_stamps.insert(expected_stamps.size(), res);
    clear_parse();
  endtask

  initial clear_parse();

  // ---------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------
  task automatic queue_bytes(input byte unsigned txt[$], input bit mark_end);
    char_beat_t b;
    foreach (txt[i]) begin
      b.ch   = txt[i];
      b.last = mark_end && (i == txt.size() - 1);
      text_beats.insert(text_beats.size(), b);
    end
  endtask

  task automatic queue_text(input string s, input bit mark_end);
    byte unsigned txt[$];
    for (int i = 0; i < s.len(); i++) txt.insert(txt.size(), s[i]);
    queue_bytes(txt, mark_end);
  endtask

  // Mostly well-formed timestamps with occasional out-of-range fields,
  // then a few corrupted or unterminated ones.
  task automatic queue_random_stamp();
    byte unsigned txt[$];
    string        s;
    int unsigned  yy, mo, dy, hh, mi, ss, mss, dim, pick;
    int unsigned  picks[9] = '{0, 1, 1899, 1900, 1969, 1970, 2000, 2024, 9999};
    yy = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 9999) : picks[$urandom_range(0, 8)];
    pick = $urandom_range(0, 99);
    mo = (pick < 90) ? $urandom_range(1, 12) :
         (pick < 94) ? 0 : (pick < 97) ? 13 : $urandom_range(0, 99);
    dim  = days_in_month(yy, mo);
    pick = $urandom_range(0, 99);
    if (pick < 85)      dy = $urandom_range(1, (dim == 0) ? 31 : dim);
    else if (pick < 90) dy = 0;
    else if (pick < 96) dy = dim + 1;
    else                dy = $urandom_range(0, 99);
    hh  = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 23) : $urandom_range(24, 99);
    mi  = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 59) : $urandom_range(60, 99);
    ss  = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 59) : $urandom_range(60, 99);
    mss = $urandom_range(0, 999);
    s = $sformatf("%04d-%02d-%02d %02d:%02d:%02d", yy, mo, dy, hh, mi, ss);
    if ($urandom_range(0, 1)) s = {s, $sformatf(".%03d", mss)};
    for (int i = 0; i < s.len(); i++) txt.insert(txt.size(), s[i]);

    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (pick < 11) begin
      void'(txt.pop_back());
    end else if (pick < 14) begin
      txt.insert(txt.size(), 8'(CharZero + $urandom_range(0, 9)));
    end else if (pick < 17) begin
      repeat ($urandom_range(1, 8)) txt.insert(txt.size(), 8'($urandom_range(0, 255)));
    end
    // rarely leave the string open so it runs into the next one
    queue_bytes(txt, $urandom_range(0, 99) >= 3);
  endtask

  task automatic queue_noise();
    byte unsigned txt[$];
    repeat ($urandom_range(1, 30)) txt.insert(txt.size(), 8'($urandom_range(0, 255)));
    queue_bytes(txt, 1'b1);
  endtask

  // ---------------------------------------------------------------------
  // Input driver: presents text_beats[0]; random gaps between beats
  // ---------------------------------------------------------------------
  int unsigned in_gap  = 0;
  int unsigned in_calm = 0;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      chr_if.valid <= 1'b0;
    end else if (!chr_if.valid || chars_taken == chars_offered) begin
      if (in_gap > 0 || text_beats.size() == 0) begin
        if (in_gap > 0) in_gap--;
        chr_if.valid     <= 1'b0;
        chr_if.character <= 8'($urandom);
        chr_if.last_char <= 1'($urandom);
      end else begin
        chr_if.valid     <= 1'b1;
        chr_if.character <= text_beats[0].ch;
        chr_if.last_char <= text_beats[0].last;
        chars_offered++;
        if (in_calm > 0) begin
          in_calm--;
          in_gap = 0;
        end else begin
          in_gap = idle_len();
          if ($urandom_range(0, 99) < 3) in_calm = $urandom_range(40, 150);
        end
      end
    end
  end

  // Accepted character beats feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && chr_if.valid && chr_if.ready) begin
      absorb_char(chr_if.character, chr_if.last_char);
      void'(text_beats.pop_front());
      chars_taken++;
    end
  end

  // ---------------------------------------------------------------------
  // Output side: random stalls, plus one long hold-off once results flow,
  // long enough that the record queue fills and the input stalls.
  // ---------------------------------------------------------------------
  int unsigned out_gap   = 0;
  int unsigned out_calm  = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else if (!hold_done && results_seen >= 20) begin
      hold_done = 1'b1;
      hold_left = 600;
      res_if.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
      if (out_calm > 0) begin
        out_calm--;
      end else begin
        out_gap = idle_len();
        if ($urandom_range(0, 99) < 3) out_calm = $urandom_range(40, 150);
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    stamp_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      if (expected_stamps.size() == 0) begin
        $error("unexpected result beat: epoch_millis %0d valid_res %0b",
               res_if.epoch_millis, res_if.valid_res);
        mismatches++;
      end else begin
        want = expected_stamps.pop_front();
        if (res_if.epoch_millis !== want.millis) begin
          $error("epoch_millis: expected %0d, got %0d", want.millis, res_if.epoch_millis);
          mismatches++;
        end
        if (res_if.valid_res !== want.ok) begin
          $error("valid_res: expected %0b, got %0b", want.ok, res_if.valid_res);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    byte unsigned odd_bytes[$];

    // directed: epoch, range ends, leap rules, each range and format fault
    queue_text("1970-01-01 00:00:00", 1'b1);
    queue_text("0000-01-01 00:00:00.000", 1'b1);
    queue_text("9999-12-31 23:59:59.999", 1'b1);
    queue_text("1969-12-31 23:59:59.999", 1'b1);
    queue_text("2000-02-29 12:34:56.789", 1'b1);
    queue_text("1900-02-29 00:00:00", 1'b1);
    queue_text("2023-02-29 00:00:00", 1'b1);
    queue_text("2024-02-29 23:59:59", 1'b1);
    queue_text("2021-04-31 08:00:00", 1'b1);
    queue_text("2021-00-10 08:00:00", 1'b1);
    queue_text("2021-13-01 08:00:00", 1'b1);
    queue_text("2021-06-00 08:00:00", 1'b1);
    queue_text("2021-06-15 24:00:00", 1'b1);
    queue_text("2021-06-15 23:60:00", 1'b1);
    queue_text("2021-06-15 23:59:60", 1'b1);
    queue_text("-021-06-15 10:00:00", 1'b1);       // sign in a digit place
    queue_text("2021/06/15 10:00:00", 1'b1);
    queue_text("2021-06-15T10:00:00", 1'b1);
    queue_text("2021-06-15 10:00:00,123", 1'b1);
    queue_text("2021-06-15 10:00:00.1", 1'b1);     // length 21
    queue_text("7", 1'b1);
    queue_text("2021-06-15 10:00:00.123456789", 1'b1); // runs past the 23rd
    queue_text("2021-06-15 10:00:00", 1'b0);       // no end mark, runs on
    queue_text("2021-06-15 10:00:00", 1'b1);
    odd_bytes = '{8'hFF, 8'h00, 8'h7F, 8'h80};
    queue_bytes(odd_bytes, 1'b1);

    // random part
    while (text_beats.size() < 1400) begin
      if ($urandom_range(0, 99) < 85) queue_random_stamp();
      else                            queue_noise();
    end
    // close any string left open at the very end
    queue_text("2038-01-19 03:14:07", 1'b1);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (text_beats.size() != 0 || expected_stamps.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
